### design/segp2d_pkg.sv
// Shared constants and request codes for the 2D segment predicate core.
`timescale 1ns / 1ps

package segp2d_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FIELD_BITS     = 32;
    localparam int EPS_BITS       = 32;

    localparam logic [EPS_BITS-1:0] EPS_RESET = 32'd65536;

    localparam logic [1:0] OP_ON_SEG = 2'd0;
    localparam logic [1:0] OP_INSIDE = 2'd1;
    localparam logic [1:0] OP_CROSS  = 2'd2;

endpackage

### design/segp2d_pair.sv
// Two-stage product pair: registered a0*b0 and a1*b1, then their registered sum or difference.
`timescale 1ns / 1ps

module segp2d_pair #(
    parameter int COORD_BITS = segp2d_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          sub,
    input  logic signed [COORD_BITS:0]    a0,
    input  logic signed [COORD_BITS:0]    b0,
    input  logic signed [COORD_BITS:0]    a1,
    input  logic signed [COORD_BITS:0]    b1,
    output logic signed [2*COORD_BITS+2:0] result
);

    import segp2d_pkg::*;

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;
    localparam int R = P + 1;

    logic signed [P-1:0] prod0_reg;
    logic signed [P-1:0] prod1_reg;
    logic                sub_reg;
    logic signed [R-1:0] ext0;
    logic signed [R-1:0] ext1;
    logic signed [R-1:0] sum_next;
    logic signed [R-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        prod0_reg <= a0 * b0;
        prod1_reg <= a1 * b1;
        sub_reg   <= sub;
    end

    always_comb
    begin
        ext0     = {prod0_reg[P-1], prod0_reg};
        ext1     = {prod1_reg[P-1], prod1_reg};
        sum_next = sub_reg ? (ext0 - ext1) : (ext0 + ext1);
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign result = sum_reg;

endmodule

### design/segment_predicate_2d_core.sv
// Top level of the 2D segment predicate core: five-stage pipeline, one request per cycle.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+----------------------------------------
//   request   | start / busy               | req_type, p1_x, p1_y, p2_x, p2_y,
//             |                            | q1_x, q1_y, q2_x, q2_y
//   result    | done (one-cycle strobe)    | hit
//   config    | cfg_valid / cfg_ready      | cfg_data (epsilon)
//
// A request is taken in every cycle in which busy is low; its hit appears with done. Depth
// is set by the differences, the 33x33 multipliers, the sums,
// the epsilon subtract and the final compares, one register stage each.
// After reset, busy is high for one cycle and epsilon holds 65536.
// The receiver cannot hold off results, so the pipeline never stalls.
`timescale 1ns / 1ps

module segment_predicate_2d_core #(
    parameter int COORD_BITS = segp2d_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] p1_x,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] p1_y,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] p2_x,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] p2_y,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] q1_x,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] q1_y,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] q2_x,
    input  logic [segp2d_pkg::FIELD_BITS-1:0] q2_y,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [segp2d_pkg::EPS_BITS-1:0]   cfg_data,
    output logic                              hit,
    output logic                              done
);

    import segp2d_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int R  = 2 * D + 1;
    localparam int CW = (2 * C + 4 > EPS_BITS + 2) ? (2 * C + 4) : (EPS_BITS + 2);

    function automatic logic signed [D-1:0] coord(input logic [FIELD_BITS-1:0] v);
        coord = {v[C-1], v[C-1:0]};
    endfunction

    function automatic logic signed [CW-1:0] widen(input logic signed [R-1:0] v);
        widen = {{(CW-R){v[R-1]}}, v};
    endfunction

    // configuration and control
    logic [EPS_BITS-1:0] eps_reg;
    logic                busy_reg;
    logic                busy_next;
    logic                accept;
    logic [4:0]          vld_reg;

    // stage 1: coordinate differences
    logic signed [D-1:0] abx_reg, aby_reg;
    logic signed [D-1:0] ux_reg, uy_reg;
    logic signed [D-1:0] vx_reg, vy_reg;
    logic signed [D-1:0] pqx_reg, pqy_reg;
    logic signed [D-1:0] wx_reg, wy_reg;
    logic signed [D-1:0] zx_reg, zy_reg;
    logic [1:0]          op1_reg, op2_reg, op3_reg, op4_reg;

    // stage 3: cross and dot products out of the pair units
    logic signed [R-1:0] d1_s, d2_s, d3_s, d4_s, t1_s, t2_s, len_s;

    // stage 4
    logic signed [CW-1:0] eps_w;
    logic signed [CW-1:0] d1_w, d2_w, d3_w, d4_w, t1_w, t2_w, len_w;
    logic signed [CW-1:0] upper_next, absd1_next, absd2_next;
    logic signed [CW-1:0] thi_next, tlo_next;
    logic                 opp12_next, opp34_next;
    logic signed [CW-1:0] upper_reg, absd1_reg, absd2_reg;
    logic signed [CW-1:0] t1_reg, thi_reg, tlo_reg, len_reg;
    logic                 opp12_reg, opp34_reg;

    // stage 5
    logic c1, c2;
    logic hit_next;
    logic hit_reg;

    assign accept    = start && !busy_reg;
    assign busy_next = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg  <= EPS_RESET;
            busy_reg <= 1'b1;
            vld_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                eps_reg <= cfg_data;
            end
            busy_reg <= busy_next;
            vld_reg  <= {vld_reg[3:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        abx_reg <= coord(q2_x) - coord(q1_x);
        aby_reg <= coord(q2_y) - coord(q1_y);
        ux_reg  <= coord(p1_x) - coord(q1_x);
        uy_reg  <= coord(p1_y) - coord(q1_y);
        vx_reg  <= coord(p2_x) - coord(q1_x);
        vy_reg  <= coord(p2_y) - coord(q1_y);
        pqx_reg <= coord(p2_x) - coord(p1_x);
        pqy_reg <= coord(p2_y) - coord(p1_y);
        wx_reg  <= coord(q1_x) - coord(p1_x);
        wy_reg  <= coord(q1_y) - coord(p1_y);
        zx_reg  <= coord(q2_x) - coord(p1_x);
        zy_reg  <= coord(q2_y) - coord(p1_y);
        op1_reg <= req_type;
        op2_reg <= op1_reg;
        op3_reg <= op2_reg;
        op4_reg <= op3_reg;
    end

    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_d1 (
        .clk(clk), .sub(1'b1),
        .a0(abx_reg), .b0(uy_reg), .a1(aby_reg), .b1(ux_reg), .result(d1_s)
    );
    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_d2 (
        .clk(clk), .sub(1'b1),
        .a0(abx_reg), .b0(vy_reg), .a1(aby_reg), .b1(vx_reg), .result(d2_s)
    );
    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_d3 (
        .clk(clk), .sub(1'b1),
        .a0(pqx_reg), .b0(wy_reg), .a1(pqy_reg), .b1(wx_reg), .result(d3_s)
    );
    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_d4 (
        .clk(clk), .sub(1'b1),
        .a0(pqx_reg), .b0(zy_reg), .a1(pqy_reg), .b1(zx_reg), .result(d4_s)
    );
    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_t1 (
        .clk(clk), .sub(1'b0),
        .a0(abx_reg), .b0(ux_reg), .a1(aby_reg), .b1(uy_reg), .result(t1_s)
    );
    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_t2 (
        .clk(clk), .sub(1'b0),
        .a0(abx_reg), .b0(vx_reg), .a1(aby_reg), .b1(vy_reg), .result(t2_s)
    );
    segp2d_pair #(.COORD_BITS(COORD_BITS)) u_len (
        .clk(clk), .sub(1'b0),
        .a0(abx_reg), .b0(abx_reg), .a1(aby_reg), .b1(aby_reg), .result(len_s)
    );

    always_comb
    begin
        eps_w = {{(CW-EPS_BITS){1'b0}}, eps_reg};
        d1_w  = widen(d1_s);
        d2_w  = widen(d2_s);
        d3_w  = widen(d3_s);
        d4_w  = widen(d4_s);
        t1_w  = widen(t1_s);
        t2_w  = widen(t2_s);
        len_w = widen(len_s);

        upper_next = len_w - eps_w;
        absd1_next = d1_w[CW-1] ? -d1_w : d1_w;
        absd2_next = d2_w[CW-1] ? -d2_w : d2_w;

        // strict sign change: a zero never counts
        opp12_next = (d1_w[CW-1] && !d2_w[CW-1] && (d2_w != '0))
                  || (d2_w[CW-1] && !d1_w[CW-1] && (d1_w != '0));
        opp34_next = (d3_w[CW-1] && !d4_w[CW-1] && (d4_w != '0))
                  || (d4_w[CW-1] && !d3_w[CW-1] && (d3_w != '0));

        if (t1_w < t2_w)
        begin
            thi_next = t2_w;
            tlo_next = t1_w;
        end
        else
        begin
            thi_next = t1_w;
            tlo_next = t2_w;
        end
    end

    always_ff @(posedge clk)
    begin
        upper_reg <= upper_next;
        absd1_reg <= absd1_next;
        absd2_reg <= absd2_next;
        opp12_reg <= opp12_next;
        opp34_reg <= opp34_next;
        t1_reg    <= t1_w;
        thi_reg   <= thi_next;
        tlo_reg   <= tlo_next;
        len_reg   <= len_w;
    end

    always_comb
    begin
        c1 = absd1_reg <= eps_w;
        c2 = absd2_reg <= eps_w;
        case (op4_reg)
            OP_ON_SEG:
            begin
                hit_next = c1 && !t1_reg[CW-1] && (t1_reg <= len_reg);
            end
            OP_INSIDE:
            begin
                hit_next = c1 && (t1_reg > eps_w) && (t1_reg < upper_reg);
            end
            OP_CROSS:
            begin
                hit_next = (opp12_reg && opp34_reg)
                        || (c1 && c2 && (thi_reg > eps_w) && (tlo_reg < upper_reg));
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign busy = busy_reg;
    assign hit  = hit_reg;
    assign done = vld_reg[4];

endmodule

### test/testbench.sv
// Self-checking testbench for the 2D segment predicate core, with its own hit predictor.
`timescale 1ns / 1ps

module testbench;
    import segp2d_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;   // selector with no operation behind it
    localparam int PIPE_DEPTH = 5;
    localparam int U    = 65536;              // 1.0 in Q16.16
    localparam int CMIN = 32'h8000_0000;
    localparam int CMAX = 32'h7fff_ffff;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] p1x;
        logic [31:0] p1y;
        logic [31:0] p2x;
        logic [31:0] p2y;
        logic [31:0] q1x;
        logic [31:0] q1y;
        logic [31:0] q2x;
        logic [31:0] q2y;
    } req_t;

    typedef struct {
        logic [1:0] op;
        logic       hit;
        int         seq;
    } hit_expect_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [31:0] p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        hit;
    logic        done;

    hit_expect_t hit_expect_q[$];
    logic [31:0] eps_model;
    int          mismatches;
    int          req_seq;
    int          hit_count;
    int          eps_writes;
    int          op_count[4];

    segment_predicate_2d_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .p1_x      (p1_x),
        .p1_y      (p1_y),
        .p2_x      (p2_x),
        .p2_y      (p2_y),
        .q1_x      (q1_x),
        .q1_y      (q1_y),
        .q2_x      (q2_x),
        .q2_y      (q2_y),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .hit       (hit),
        .done      (done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic wide_t cross2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        return ax * by - ay * bx;
    endfunction

    function automatic wide_t dot2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        return ax * bx + ay * by;
    endfunction

    function automatic wide_t mag(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic sign_change(wide_t a, wide_t b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    function automatic logic seg_hit_predict(req_t r, logic [31:0] eps_raw);
        wide_t p1x, p1y, p2x, p2y, q1x, q1y, q2x, q2y;
        wide_t eps, abx, aby, len, upper, cr, dp;
        wide_t d1, d2, d3, d4, t1, t2, tlo, thi;
        logic  h;
        p1x = $signed(r.p1x);
        p1y = $signed(r.p1y);
        p2x = $signed(r.p2x);
        p2y = $signed(r.p2y);
        q1x = $signed(r.q1x);
        q1y = $signed(r.q1y);
        q2x = $signed(r.q2x);
        q2y = $signed(r.q2y);
        eps = {96'd0, eps_raw};
        abx = q2x - q1x;
        aby = q2y - q1y;
        len = dot2(abx, aby, abx, aby);
        upper = len - eps;
        h = 1'b0;
        case (r.op)
            OP_ON_SEG, OP_INSIDE:
            begin
                cr = cross2(abx, aby, p1x - q1x, p1y - q1y);
                if (mag(cr) <= eps)
                begin
                    dp = dot2(abx, aby, p1x - q1x, p1y - q1y);
                    if (r.op == OP_ON_SEG)
                        h = (dp >= 0) && (dp <= len);
                    else
                        h = (dp > eps) && (dp < upper);
                end
            end
            OP_CROSS:
            begin
                d1 = cross2(abx, aby, p1x - q1x, p1y - q1y);
                d2 = cross2(abx, aby, p2x - q1x, p2y - q1y);
                d3 = cross2(p2x - p1x, p2y - p1y, q1x - p1x, q1y - p1y);
                d4 = cross2(p2x - p1x, p2y - p1y, q2x - p1x, q2y - p1y);
                if (sign_change(d1, d2) && sign_change(d3, d4))
                    h = 1'b1;
                else if (mag(d1) <= eps && mag(d2) <= eps)
                begin
                    // collinear: compare projections of P onto Q
                    t1 = dot2(abx, aby, p1x - q1x, p1y - q1y);
                    t2 = dot2(abx, aby, p2x - q1x, p2y - q1y);
                    thi = (t1 < t2) ? t2 : t1;
                    tlo = (t1 < t2) ? t1 : t2;
                    h = (thi > eps) && (tlo < upper);
                end
            end
            default:
                h = 1'b0;
        endcase
        return h;
    endfunction

    // ---------------------------------------------------------------- monitor / checker

    always @(posedge clk)
    begin : result_check
        hit_expect_t e;
        req_t        r;
        if (rst_n)
        begin
            if (done)
            begin
                if (hit_expect_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: hit=%b", $realtime, hit);
                end
                else
                begin
                    e = hit_expect_q.pop_front();
                    if (hit !== e.hit)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] request %0d op %0d: hit expected %b, got %b",
                                     $realtime, e.seq, e.op, e.hit, hit);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                eps_model = cfg_data;
            if (start && !busy)
            begin
                r = '{req_type, p1_x, p1_y, p2_x, p2_y, q1_x, q1_y, q2_x, q2_y};
                e.op  = req_type;
                e.hit = seg_hit_predict(r, eps_model);
                e.seq = req_seq;
                hit_expect_q.push_back(e);
                req_seq++;
                op_count[req_type]++;
                if (e.hit)
                    hit_count++;
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_req(input req_t r, input int idle_pct);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_type <= r.op;
        p1_x     <= r.p1x;
        p1_y     <= r.p1y;
        p2_x     <= r.p2x;
        p2_y     <= r.p2y;
        q1_x     <= r.q1x;
        q1_y     <= r.q1y;
        q2_x     <= r.q2x;
        q2_y     <= r.q2y;
        start    <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (hit_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_epsilon(input logic [31:0] value);
        drain_results();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        eps_writes++;
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic req_t mk(logic [1:0] op, int ax, int ay, int bx, int by,
                                int cx, int cy, int dx, int dy);
        return '{op, ax, ay, bx, by, cx, cy, dx, dy};
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(2000) - 1000;
            2:
            begin
                case ($urandom_range(4))
                    0: v = CMIN;
                    1: v = CMAX;
                    2: v = '0;
                    3: v = '1;
                    default: v = 32'd1;
                endcase
            end
            default:
            begin
                v = $urandom >> $urandom_range(31);
                if ($urandom_range(1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic req_t gen_request();
        req_t r;
        int   s, m, k1, k2, bx, by, dx, dy, wob;
        case ($urandom_range(2))
            0: r.op = OP_ON_SEG;
            1: r.op = OP_INSIDE;
            default: r.op = OP_CROSS;
        endcase
        if ($urandom_range(99) < 7)
            r.op = OP_NONE;
        case ($urandom_range(9))
            0, 1, 2:
            begin
                r.p1x = rand_coord();
                r.p1y = rand_coord();
                r.p2x = rand_coord();
                r.p2y = rand_coord();
                r.q1x = rand_coord();
                r.q1y = rand_coord();
                r.q2x = rand_coord();
                r.q2y = rand_coord();
            end
            3, 4, 5, 6:
            begin
                // points on one line through q1, spaced by whole steps, with p1y or p2x sometimes nudged off it
                s  = $urandom_range(10);
                bx = $urandom_range(1 << 23);
                bx = bx - (1 << 22);
                by = $urandom_range(1 << 23);
                by = by - (1 << 22);
                dx = $urandom_range(128);
                dx = (dx - 64) <<< s;
                dy = $urandom_range(128);
                dy = (dy - 64) <<< s;
                m  = $urandom_range(8, 1);
                k1 = $urandom_range(m + 4);
                k1 = k1 - 2;
                k2 = $urandom_range(m + 4);
                k2 = k2 - 2;
                r.q1x = bx;
                r.q1y = by;
                r.q2x = bx + m * dx;
                r.q2y = by + m * dy;
                r.p1x = bx + k1 * dx;
                r.p1y = by + k1 * dy;
                r.p2x = bx + k2 * dx;
                r.p2y = by + k2 * dy;
                if ($urandom_range(1))
                begin
                    wob = $urandom_range(6);
                    r.p1y = r.p1y + ((wob - 3) <<< $urandom_range(s));
                end
                if ($urandom_range(3) == 0)
                begin
                    wob = $urandom_range(6);
                    r.p2x = r.p2x + ((wob - 3) <<< $urandom_range(s));
                end
            end
            default:
            begin
                s = $urandom_range(14);
                r.p1x = ($urandom_range(400) - 200) << s;
                r.p1y = ($urandom_range(400) - 200) << s;
                r.p2x = ($urandom_range(400) - 200) << s;
                r.p2y = ($urandom_range(400) - 200) << s;
                r.q1x = ($urandom_range(400) - 200) << s;
                r.q1y = ($urandom_range(400) - 200) << s;
                r.q2x = ($urandom_range(400) - 200) << s;
                r.q2y = ($urandom_range(400) - 200) << s;
            end
        endcase
        return r;
    endfunction

    task automatic send_directed(input int idle_pct);
        // Q runs from (0,0) to (4,0) unless noted
        send_req(mk(OP_ON_SEG, 2*U, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_ON_SEG, 0, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_ON_SEG, 4*U, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_ON_SEG, 5*U, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_ON_SEG, 2*U, U, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_INSIDE, 0, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_INSIDE, 2*U, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_INSIDE, 4*U, 0, 0, 0, 0, 0, 4*U, 0), idle_pct);
        // zero-length Q
        send_req(mk(OP_ON_SEG, U, U, 0, 0, U, U, U, U), idle_pct);
        send_req(mk(OP_ON_SEG, U + 1, U, 0, 0, U, U, U, U), idle_pct);
        send_req(mk(OP_INSIDE, U, U, 0, 0, U, U, U, U), idle_pct);
        // crossing (Q from (0,4) to (4,0)), touching at an endpoint, collinear overlap and gap, parallel, no-op
        send_req(mk(OP_CROSS, 0, 0, 4*U, 4*U, 0, 4*U, 4*U, 0), idle_pct);
        send_req(mk(OP_CROSS, 2*U, 0, 2*U, 2*U, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_CROSS, U, 0, 3*U, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_CROSS, 5*U, 0, 6*U, 0, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_CROSS, 0, U, 4*U, U, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_NONE, 0, 0, 4*U, 4*U, 0, 4*U, 4*U, 0), idle_pct);
        // p2 carries junk that point tests must ignore
        send_req(mk(OP_ON_SEG, 2*U, 0, CMIN, CMAX, 0, 0, 4*U, 0), idle_pct);
        send_req(mk(OP_INSIDE, 2*U, 0, CMAX, CMIN, 0, 0, 4*U, 0), idle_pct);
        // full-scale coordinates push the products past 64 bits
        send_req(mk(OP_CROSS, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN), idle_pct);
        send_req(mk(OP_ON_SEG, 0, 0, 0, 0, CMIN, CMIN, CMAX, CMAX), idle_pct);
        send_req(mk(OP_INSIDE, -1, 0, 0, 0, CMAX, 0, CMIN, 0), idle_pct);
        send_req(mk(OP_ON_SEG, -1, -1, -1, -1, -1, -1, 0, 0), idle_pct);
    endtask

    task automatic send_random(input int count, input int idle_pct);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(199) == 0)
                drain_results();
            send_req(gen_request(), idle_pct);
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_reset_eps();
        send_directed(0);
    endtask

    task automatic test_eps_extremes();
        set_epsilon('0);
        send_directed(36);
        set_epsilon('1);
        send_directed(0);
        set_epsilon(EPS_RESET);
    endtask

    task automatic test_pause_to_empty();
        send_random(20, 0);
        drain_results();
        send_random(20, 0);
    endtask

    task automatic test_random_phases();
        send_random(320, 0);
        set_epsilon('0);
        send_random(320, 73);
        set_epsilon(32'd1);
        send_random(320, 36);
        set_epsilon($urandom);
        send_random(320, 0);
        set_epsilon('1);
        send_random(320, 73);
        set_epsilon($urandom_range(4096));
        send_random(320, 36);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        start      <= 1'b0;
        req_type   <= OP_ON_SEG;
        p1_x       <= '0;
        p1_y       <= '0;
        p2_x       <= '0;
        p2_y       <= '0;
        q1_x       <= '0;
        q1_y       <= '0;
        q2_x       <= '0;
        q2_y       <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        eps_model  = EPS_RESET;
        mismatches = 0;
        req_seq    = 0;
        hit_count  = 0;
        eps_writes = 0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_reset_eps();
        test_eps_extremes();
        test_pause_to_empty();
        test_random_phases();

        drain_results();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Ran %0d requests: %0d on-segment, %0d strictly-inside, %0d intersect, %0d unknown",
                 req_seq, op_count[OP_ON_SEG], op_count[OP_INSIDE], op_count[OP_CROSS],
                 op_count[OP_NONE]);
        $display("%0d hits, %0d epsilon writes, sender gaps of 0/36/73 percent, %0d mismatches",
                 hit_count, eps_writes, mismatches);
        if (mismatches == 0 && hit_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
